// ===== rtl/core/sobm_pkg.sv =====
package sobm_pkg;

  // Default frame limits for the line stores and row*width products.
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Field and register widths.
  localparam int PIX_W        = 8;
  localparam int ROW_W        = 16;
  localparam int IMG_WIDTH_W  = 12;
  localparam int IMG_HEIGHT_W = 13;

  // Register reset values.
  localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // Register indexes on the configuration port.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Input transaction.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             flush;
  } pixel_in_t;

  // Output transaction.
  typedef struct packed {
    logic [PIX_W-1:0] edge_magnitude;
    logic             row_end;
    logic             frame_end;
  } edge_out_t;

  // 3x3 window, indexed [row][column]; row 0 is the top, column 0 the left.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // One classified center, masked taps plus its position flags.
  typedef struct packed {
    window_t taps;
    logic    row_end;
    logic    frame_end;
  } center_t;

endpackage

// ===== rtl/core/sobm_front.sv =====
module sobm_front
  import sobm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IMG_WIDTH_W-1:0]  image_width,
  input  logic [IMG_HEIGHT_W-1:0] image_height,
  input  logic                    cfg_write,
  input  logic                    pixel_valid,
  input  pixel_in_t               pixel,
  output logic                    pixel_stall,
  input  logic                    queue_full,
  output logic                    push,
  output center_t                 push_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XW = WW + 1;
  localparam int YW = ROW_W + 1;
  localparam int PW = ROW_W + WW;
  localparam int LW = PW + 1;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [XW-1:0]    w_x, in_col_p1, out_col_p1;
  logic [YW-1:0]    h_y, out_row_p1;
  logic [CW-1:0]    in_col, in_col_next, out_col, out_col_next, raddr;
  logic [ROW_W-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [PW-1:0]    prod_in, prod_out;
  logic [LW-1:0]    lin_in, lin_lag;
  logic             fresh, fresh_next;
  logic             accept, emit, in_wrap, row_end, frame_end;
  logic [2:0]       use_row, use_col;
  logic [PIX_W-1:0] p, older_rd, newer_rd;
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  window_t          win, win_new;

  // Effective frame size: zero acts as one, large values clamp to the limit.
  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  // Position compares for both the input and the output counters.
  assign w_x        = XW'(w_eff);
  assign h_y        = YW'(h_eff);
  assign in_col_p1  = XW'(in_col) + XW'(1);
  assign out_col_p1 = XW'(out_col) + XW'(1);
  assign out_row_p1 = YW'(out_row) + YW'(1);
  assign in_wrap    = in_col_p1 >= w_x;
  assign row_end    = out_col_p1 >= w_x;
  assign frame_end  = row_end && (out_row_p1 >= h_y);
  assign use_row    = {out_row_p1 < h_y, 1'b1, out_row != '0};
  assign use_col    = {out_col_p1 < w_x, 1'b1, out_col != '0};

  // Linear positions use the registered row*width products.
  assign lin_in  = LW'(prod_in) + LW'(in_col);
  assign lin_lag = LW'(prod_out) + LW'(out_col) + LW'(w_eff) + LW'(1);
  assign emit    = lin_in >= lin_lag;

  // Hold off input while the products are stale or the queue has no room.
  assign pixel_stall = !fresh || queue_full;
  assign accept      = pixel_valid && !pixel_stall;
  assign push        = accept && emit;

  // Flush items and pixels past the frame's last row enter as zero.
  assign p = (pixel.flush || (YW'(in_row) >= h_y)) ? '0 : pixel.pixel_value;

  // Window after this transaction's shift.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_new[r][0] = win[r][1];
      win_new[r][1] = win[r][2];
    end
    win_new[0][2] = older_rd;
    win_new[1][2] = newer_rd;
    win_new[2][2] = p;
  end

  // Taps outside the frame are zeroed before the center is queued.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_data.taps[r][c] = (use_row[r] && use_col[c]) ? win_new[r][c] : '0;
      end
    end
    push_data.row_end   = row_end;
    push_data.frame_end = frame_end;
  end

  // Counter advance; the last center of a frame restarts all counters.
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (accept) begin
      if (in_wrap) begin
        in_col_next = '0;
        if (in_row != '1) begin
          in_row_next = in_row + ROW_W'(1);
        end
      end else begin
        in_col_next = in_col_p1[CW-1:0];
      end
      if (emit) begin
        if (frame_end) begin
          in_col_next  = '0;
          in_row_next  = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if (row_end) begin
          out_col_next = '0;
          if (out_row != '1) begin
            out_row_next = out_row + ROW_W'(1);
          end
        end else begin
          out_col_next = out_col_p1[CW-1:0];
        end
      end
    end
  end

  // Products go stale whenever a row counter or a register changes.
  assign fresh_next = !(cfg_write || (accept && (in_wrap || (emit && row_end))));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      fresh   <= 1'b0;
      win     <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      fresh   <= fresh_next;
      if (accept) begin
        win <= win_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_in  <= PW'(in_row) * PW'(w_eff);
    prod_out <= PW'(out_row) * PW'(w_eff);
  end

  // Line stores are read ahead at the next column, with write-first bypass.
  assign raddr = rst ? '0 : in_col_next;

  always_ff @(posedge clk) begin
    if (accept) begin
      older_mem[in_col] <= newer_rd;
      newer_mem[in_col] <= p;
    end
    if (accept && (in_col == raddr)) begin
      older_rd <= newer_rd;
      newer_rd <= p;
    end else begin
      older_rd <= older_mem[raddr];
      newer_rd <= newer_mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sobm_queue.sv =====
module sobm_queue
  import sobm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  center_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output center_t pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  center_t        slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full     = count == (AW + 1)'(DEPTH);
  assign q_valid  = count != '0;
  assign pop_data = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (!push && pop) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/sobm_back.sv =====
module sobm_back
  import sobm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  center_t   q_data,
  output logic      q_pop,
  output logic      result_valid,
  input  logic      result_stall,
  output edge_out_t result
);

  localparam int NS = 8;
  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

  logic adv;

  // Gradient stage.
  logic              g_vld, g_re, g_fe;
  logic signed [10:0] gx, gy;
  logic [9:0]         col_l, col_r, row_t, row_b;
  logic [10:0]        gx_next, gy_next;

  // Square stage.
  logic               q2_vld, q2_re, q2_fe;
  logic signed [21:0] sqx_full, sqy_full;
  logic [19:0]        sqx, sqy;

  // Sum stage.
  logic        s_vld, s_re, s_fe, s_sat;
  logic [20:0] s_full;
  logic [15:0] s_val;

  // Root stages, one result bit each.
  logic [NS-1:0]    st_vld, st_sat, st_re, st_fe;
  logic [15:0]      st_s    [NS];
  logic [8:0]       st_rem  [NS];
  logic [PIX_W-1:0] st_root [NS];
  logic [15:0]      in_s    [NS];
  logic [8:0]       in_rem  [NS];
  logic [PIX_W-1:0] in_root [NS];
  logic [8:0]       nx_rem  [NS];
  logic [PIX_W-1:0] nx_root [NS];
  logic [10:0]      trial_rem, trial;

  // The whole pipeline moves unless a finished result is held.
  assign adv   = !st_vld[NS-1] || !result_stall;
  assign q_pop = q_valid && adv;

  // Column and row sums with weights 1, 2, 1.
  always_comb begin
    col_l   = 10'(q_data.taps[0][0]) + {1'b0, q_data.taps[1][0], 1'b0}
              + 10'(q_data.taps[2][0]);
    col_r   = 10'(q_data.taps[0][2]) + {1'b0, q_data.taps[1][2], 1'b0}
              + 10'(q_data.taps[2][2]);
    row_t   = 10'(q_data.taps[0][0]) + {1'b0, q_data.taps[0][1], 1'b0}
              + 10'(q_data.taps[0][2]);
    row_b   = 10'(q_data.taps[2][0]) + {1'b0, q_data.taps[2][1], 1'b0}
              + 10'(q_data.taps[2][2]);
    gx_next = {1'b0, col_l} - {1'b0, col_r};
    gy_next = {1'b0, row_t} - {1'b0, row_b};
  end

  assign sqx_full = gx * gx;
  assign sqy_full = gy * gy;
  assign s_full   = 21'(sqx) + 21'(sqy);

  // Stage inputs of the root chain.
  always_comb begin
    in_s[0]    = s_val;
    in_rem[0]  = '0;
    in_root[0] = '0;
    for (int k = 1; k < NS; k++) begin
      in_s[k]    = st_s[k-1];
      in_rem[k]  = st_rem[k-1];
      in_root[k] = st_root[k-1];
    end
  end

  // One restoring square-root step per stage, top bit pair first.
  always_comb begin
    trial_rem = '0;
    trial     = '0;
    for (int k = 0; k < NS; k++) begin
      trial_rem = {in_rem[k], in_s[k][2*(NS-1-k) +: 2]};
      trial     = {1'b0, in_root[k], 2'b01};
      if (trial_rem >= trial) begin
        nx_rem[k]  = 9'(trial_rem - trial);
        nx_root[k] = {in_root[k][PIX_W-2:0], 1'b1};
      end else begin
        nx_rem[k]  = trial_rem[8:0];
        nx_root[k] = {in_root[k][PIX_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld  <= 1'b0;
      q2_vld <= 1'b0;
      s_vld  <= 1'b0;
      st_vld <= '0;
    end else if (adv) begin
      g_vld  <= q_valid;
      q2_vld <= g_vld;
      s_vld  <= q2_vld;
      st_vld <= {st_vld[NS-2:0], s_vld};
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      gx     <= gx_next;
      gy     <= gy_next;
      g_re   <= q_data.row_end;
      g_fe   <= q_data.frame_end;
      sqx    <= sqx_full[19:0];
      sqy    <= sqy_full[19:0];
      q2_re  <= g_re;
      q2_fe  <= g_fe;
      s_val  <= s_full[15:0];
      s_sat  <= |s_full[20:16];
      s_re   <= q2_re;
      s_fe   <= q2_fe;
      st_sat <= {st_sat[NS-2:0], s_sat};
      st_re  <= {st_re[NS-2:0], s_re};
      st_fe  <= {st_fe[NS-2:0], s_fe};
      for (int k = 0; k < NS; k++) begin
        st_s[k]    <= in_s[k];
        st_rem[k]  <= nx_rem[k];
        st_root[k] <= nx_root[k];
      end
    end
  end

  // Any sum of 2^16 or more saturates.
  assign result_valid          = st_vld[NS-1];
  assign result.edge_magnitude = st_sat[NS-1] ? MAG_MAX : st_root[NS-1];
  assign result.row_end        = st_re[NS-1];
  assign result.frame_end      = st_fe[NS-1];

endmodule

// ===== rtl/core/sobel_edge_magnitude.sv =====
// Channel  Dir  Handshake                     Payload
// pixel    in   pixel_valid / pixel_stall     pixel_in_t (pixel_value, flush)
// result   out  result_valid / result_stall   edge_out_t (magnitude, row_end, frame_end)
// config   in   APB psel / penable / pready   image_width @ 0x0, image_height @ 0x4
//
// One pixel is taken per clock while pixel_stall is low. Input stalls after reset, after
// each input or output row wrap and after each register write, while the registered
// row*width products refresh. After the transaction that completes its window, a result
// passes three arithmetic stages, then eight square-root stages.
// Reset is synchronous and clears counters, window, queue and pipeline valids, not the
// line stores. A held result freezes the back pipeline; the four-entry queue fills first.
module sobel_edge_magnitude
  import sobm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  pixel_in_t   pixel,
  output logic        result_valid,
  input  logic        result_stall,
  output edge_out_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic                    cfg_write;
  logic                    q_push, q_full, q_pop, q_valid;
  center_t                 q_in, q_out;

  // Register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Front: window, line stores and center classification.
  sobm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .cfg_write    (cfg_write),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .pixel_stall  (pixel_stall),
    .queue_full   (q_full),
    .push         (q_push),
    .push_data    (q_in)
  );

  // Queue between classification and arithmetic.
  sobm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .pop_data  (q_out)
  );

  // Back: gradients, squares and square root.
  sobm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("center queued while the queue is full");

  a_cfg_refresh: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> pixel_stall)
    else $error("input taken before products refreshed after a register write");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_end) |-> result.row_end)
    else $error("frame end given on a result that does not end a row");
`endif

endmodule
